>>> design/tvf_pkg.sv
// Shared types, character codes and byte classification for the text view filter.
package tvf_pkg;

   localparam int COUNT_W     = 20;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int BODY_MAX    = 4;
   localparam int BODY_LEN_W  = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_DASH   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_QMARK  = 8'h3F;
   localparam logic [7:0] CHAR_I      = 8'h49;
   localparam logic [7:0] CHAR_M      = 8'h4D;
   localparam logic [7:0] CHAR_CARET  = 8'h5E;

   localparam logic [7:0] CTRL_LAST   = 8'd31;
   localparam logic [7:0] CHAR_DEL    = 8'd127;
   localparam logic [7:0] META_BASE   = 8'd128;
   localparam logic [7:0] META_PRINT  = 8'd160;
   localparam logic [7:0] META_DEL    = 8'd255;
   localparam logic [7:0] CTRL_OFFSET = 8'd64;

   typedef enum logic [2:0] {
      REG_NUMBER_NONBLANK  = 3'd0,
      REG_NUMBER_ALL       = 3'd1,
      REG_SQUEEZE_BLANK    = 3'd2,
      REG_SHOW_TABS        = 3'd3,
      REG_SHOW_ENDS        = 3'd4,
      REG_SHOW_NONPRINTING = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic number_nonblank;
      logic number_all;
      logic squeeze_blank;
      logic show_tabs;
      logic show_ends;
      logic show_nonprinting;
   } cfg_type;

   // bytes[0] goes out first
   typedef struct packed {
      logic [BODY_MAX-1:0][7:0] bytes;
      logic [BODY_LEN_W-1:0]    len;
   } body_type;

   function automatic logic [31:0] number_max(input int digits);
      logic [31:0] m;
      m = 32'd1;
      for (int i = 0; i < digits; i++) begin
         m = m * 32'd10;
      end
      return m - 32'd1;
   endfunction

   // Display bytes of one input byte, without any line number prefix.
   function automatic body_type classify(input logic [7:0] b, input cfg_type cfg);
      body_type r;
      r.bytes    = '0;
      r.bytes[0] = b;
      r.len      = BODY_LEN_W'(1);
      if (b == CHAR_TAB && cfg.show_tabs) begin
         r.bytes[0] = CHAR_CARET;
         r.bytes[1] = CHAR_I;
         r.len      = BODY_LEN_W'(2);
      end else if (b == CHAR_NL) begin
         if (cfg.show_ends) begin
            r.bytes[0] = CHAR_DOLLAR;
            r.bytes[1] = CHAR_NL;
            r.len      = BODY_LEN_W'(2);
         end
      end else if (cfg.show_nonprinting && b != CHAR_TAB) begin
         if (b <= CTRL_LAST) begin
            r.bytes[0] = CHAR_CARET;
            r.bytes[1] = b + CTRL_OFFSET;
            r.len      = BODY_LEN_W'(2);
         end else if (b == CHAR_DEL) begin
            r.bytes[0] = CHAR_CARET;
            r.bytes[1] = CHAR_QMARK;
            r.len      = BODY_LEN_W'(2);
         end else if (b >= META_BASE) begin
            r.bytes[0] = CHAR_M;
            r.bytes[1] = CHAR_DASH;
            if (b < META_PRINT) begin
               r.bytes[2] = CHAR_CARET;
               r.bytes[3] = b - CTRL_OFFSET;
               r.len      = BODY_LEN_W'(4);
            end else if (b < META_DEL) begin
               r.bytes[2] = b - META_BASE;
               r.len      = BODY_LEN_W'(3);
            end else begin
               r.bytes[2] = CHAR_CARET;
               r.bytes[3] = CHAR_QMARK;
               r.len      = BODY_LEN_W'(4);
            end
         end
      end
      return r;
   endfunction

endpackage

>>> design/tvf_front.sv
// Front end: squeeze, line numbering state and byte classification.
module tvf_front #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tvf_pkg::cfg_type               cfg,
   input  logic                           in_valid,
   input  logic [7:0]                     in_byte,
   input  logic                           q_full,
   output logic                           push,
   output logic                           push_numbered,
   output logic [NUMBER_DIGITS-1:0][3:0]  push_digits,
   output tvf_pkg::body_type              push_body
);

   localparam logic [31:0] NUM_MAX = tvf_pkg::number_max(NUMBER_DIGITS);

   logic [1:0]                      run_ff, run_in;
   logic                            start_ff, start_in;
   logic [tvf_pkg::COUNT_W-1:0]     bin_ff, bin_in;
   logic [NUMBER_DIGITS-1:0][3:0]   bcd_ff, bcd_in;

   logic accept;
   logic is_nl;
   logic drop;
   logic numbered;
   logic [1:0] run_inc;
   logic [NUMBER_DIGITS-1:0][3:0] bcd_inc;

   assign accept  = in_valid && !q_full;
   assign is_nl   = (in_byte == tvf_pkg::CHAR_NL);
   assign run_inc = (run_ff == 2'd3) ? 2'd3 : run_ff + 2'd1;
   assign drop    = cfg.squeeze_blank && is_nl && (run_inc == 2'd3);

   assign numbered = start_ff && !drop &&
                     ((cfg.number_nonblank && !is_nl) ||
                      (!cfg.number_nonblank && cfg.number_all));

   always_comb begin
      logic carry;
      carry = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         bcd_inc[i] = bcd_ff[i];
         if (carry) begin
            if (bcd_ff[i] == 4'd9) begin
               bcd_inc[i] = 4'd0;
            end else begin
               bcd_inc[i] = bcd_ff[i] + 4'd1;
               carry      = 1'b0;
            end
         end
      end
   end

   always_comb begin
      run_in   = run_ff;
      start_in = start_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      if (accept) begin
         if (cfg.squeeze_blank) begin
            run_in = is_nl ? run_inc : 2'd0;
         end
         if (is_nl) begin
            start_in = 1'b1;
         end else if (numbered) begin
            start_in = 1'b0;
         end
         if (numbered && ({{(32 - tvf_pkg::COUNT_W){1'b0}}, bin_ff} < NUM_MAX)) begin
            bin_in = bin_ff + tvf_pkg::COUNT_W'(1);
            // holds at NUM_MAX or wraps at its width; decimal copy follows
            bcd_in = (bin_ff == '1) ? '0 : bcd_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 2'd0;
         start_ff <= 1'b1;
         bin_ff   <= tvf_pkg::COUNT_W'(1);
         bcd_ff   <= (NUMBER_DIGITS * 4)'(1);
      end else begin
         run_ff   <= run_in;
         start_ff <= start_in;
         bin_ff   <= bin_in;
         bcd_ff   <= bcd_in;
      end
   end

   assign push          = accept && !drop;
   assign push_numbered = numbered;
   assign push_digits   = bcd_ff;
   assign push_body     = tvf_pkg::classify(in_byte, cfg);

endmodule

>>> design/tvf_queue.sv
// Two-entry queue between the front end and the output sequencer.
module tvf_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output logic [DATA_W-1:0] head_data
);

   localparam int PTR_W = $clog2(tvf_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(tvf_pkg::QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [tvf_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == CNT_W'(tvf_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   // depth is a power of two, so the pointers wrap on their own
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/tvf_back.sv
// Output sequencer: emits the number prefix and display bytes, one beat a cycle while not stalled.
module tvf_back #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  logic                          q_numbered,
   input  logic [NUMBER_DIGITS-1:0][3:0] q_digits,
   input  tvf_pkg::body_type             q_body,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_last_of_run
);

   localparam int IDX_W  = $clog2(NUMBER_DIGITS + 6);
   localparam int DISP_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS + 1) : 1;
   localparam logic [IDX_W-1:0] PRE_LEN = IDX_W'(NUMBER_DIGITS + 1);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;

   logic [IDX_W-1:0] pre_len;
   logic [IDX_W-1:0] total;
   logic [IDX_W-1:0] body_off;
   logic             last_beat;
   logic             load;
   logic [NUMBER_DIGITS-1:0] lead;
   logic [7:0]       disp [NUMBER_DIGITS + 1];
   logic [7:0]       byte_sel;

   assign pre_len   = q_numbered ? PRE_LEN : '0;
   assign total     = pre_len + IDX_W'(q_body.len);
   assign body_off  = idx_ff - pre_len;
   assign last_beat = (idx_ff == total - IDX_W'(1));
   assign load      = q_valid && (!valid_ff || !rsp_stall);
   assign pop       = load && last_beat;

   // leading zeros print as spaces, the ones digit always prints
   always_comb begin
      logic all_zero;
      all_zero = 1'b1;
      for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
         all_zero = all_zero && (q_digits[i] == 4'd0);
         lead[i]  = all_zero && (i != 0);
      end
   end

   always_comb begin
      for (int k = 0; k < NUMBER_DIGITS; k++) begin
         disp[k] = lead[NUMBER_DIGITS - 1 - k] ? tvf_pkg::CHAR_SPACE :
                   tvf_pkg::CHAR_ZERO + {4'd0, q_digits[NUMBER_DIGITS - 1 - k]};
      end
      disp[NUMBER_DIGITS] = tvf_pkg::CHAR_TAB;
   end

   always_comb begin
      if (q_numbered && idx_ff < PRE_LEN) begin
         byte_sel = disp[idx_ff[DISP_W-1:0]];
      end else begin
         byte_sel = q_body.bytes[body_off[1:0]];
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = byte_sel;
         last_in  = last_beat;
         idx_in   = last_beat ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

>>> design/text_view_filter.sv
// Top level: register port, front end, queue and output sequencer.
// An accepted item passes through the queue; its output beats are registered in the output sequencer.
// Throughput: one output beat per cycle while rsp_stall is low and items are queued; an item
// produces 1 to NUMBER_DIGITS + 5 bytes, and a dropped newline produces none.
// Input is taken every cycle while the two-entry queue has room.
// Reset clears all option registers, sets the line number to 1 and empties the queue.
module text_view_filter #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_last_of_run,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tvf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tvf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tvf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int ENTRY_W = 1 + NUMBER_DIGITS * 4 + $bits(tvf_pkg::body_type);

   tvf_pkg::cfg_type     cfg_ff, cfg_in;
   tvf_pkg::reg_idx_type csr_idx;
   logic                 csr_wr;
   logic                 rd_bit;

   logic                          push, push_numbered;
   logic [NUMBER_DIGITS-1:0][3:0] push_digits;
   tvf_pkg::body_type             push_body;
   logic                          q_full, q_valid, pop;
   logic [ENTRY_W-1:0]            head_data;
   logic                          q_numbered;
   logic [NUMBER_DIGITS-1:0][3:0] q_digits;
   tvf_pkg::body_type             q_body;

   assign csr_pready = 1'b1;
   assign csr_idx    = tvf_pkg::reg_idx_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      rd_bit = 1'b0;
      unique case (csr_idx)
         tvf_pkg::REG_NUMBER_NONBLANK: begin
            rd_bit = cfg_ff.number_nonblank;
            if (csr_wr) cfg_in.number_nonblank = csr_pwdata[0];
         end
         tvf_pkg::REG_NUMBER_ALL: begin
            rd_bit = cfg_ff.number_all;
            if (csr_wr) cfg_in.number_all = csr_pwdata[0];
         end
         tvf_pkg::REG_SQUEEZE_BLANK: begin
            rd_bit = cfg_ff.squeeze_blank;
            if (csr_wr) cfg_in.squeeze_blank = csr_pwdata[0];
         end
         tvf_pkg::REG_SHOW_TABS: begin
            rd_bit = cfg_ff.show_tabs;
            if (csr_wr) cfg_in.show_tabs = csr_pwdata[0];
         end
         tvf_pkg::REG_SHOW_ENDS: begin
            rd_bit = cfg_ff.show_ends;
            if (csr_wr) cfg_in.show_ends = csr_pwdata[0];
         end
         tvf_pkg::REG_SHOW_NONPRINTING: begin
            rd_bit = cfg_ff.show_nonprinting;
            if (csr_wr) cfg_in.show_nonprinting = csr_pwdata[0];
         end
         default: begin
            rd_bit = 1'b0;
         end
      endcase
   end

   assign csr_prdata = {{(tvf_pkg::CSR_DATA_W - 1){1'b0}}, rd_bit};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tvf_front #(
      .NUMBER_DIGITS (NUMBER_DIGITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (req_valid),
      .in_byte       (req_data_byte),
      .q_full        (q_full),
      .push          (push),
      .push_numbered (push_numbered),
      .push_digits   (push_digits),
      .push_body     (push_body)
   );

   tvf_queue #(
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_numbered, push_digits, push_body}),
      .pop        (pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_data  (head_data)
   );

   assign {q_numbered, q_digits, q_body} = head_data;

   tvf_back #(
      .NUMBER_DIGITS (NUMBER_DIGITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_numbered      (q_numbered),
      .q_digits        (q_digits),
      .q_body          (q_body),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   assign req_stall = q_full;

endmodule

>>> design/tvf_checker.sv
// Port-level checks for the text view filter, bound to the top level.
module tvf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run
);

   // queue and output stage come out of reset empty
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   a_req_open_after_reset: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled right after reset");

   // the queue fills only by taking a beat
   a_stall_follows_push: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("input stall rose without an accepted beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_of_run))
      else $error("stalled result beat changed");

endmodule

bind text_view_filter tvf_checker u_tvf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run)
);
